/* rtl/dcs_pkg.sv */
// ----------------------------------------------------------------------------
// dcs_pkg
// Types and constants shared by the dryer cycle sequencer modules.
// ----------------------------------------------------------------------------
package dcs_pkg;

  // Widths of the stream words
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned IN_USED_W  = 58;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned OUT_USED_W = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_HEAT_PHASE_TIME    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRY_PHASE_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STABLE_PHASE_TIME  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COOLING_TIME       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA_PERCENT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEATER_ON_TEMP     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEATER_OFF_TEMP    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INACTIVITY_TIMEOUT = 3'd7;

  // Register reset values
  localparam logic [31:0]        RST_HEAT_PHASE_TIME    = 32'd600000;
  localparam logic [31:0]        RST_DRY_PHASE_LIMIT    = 32'd3600000;
  localparam logic [31:0]        RST_STABLE_PHASE_TIME  = 32'd300000;
  localparam logic [31:0]        RST_COOLING_TIME       = 32'd600000;
  localparam logic [6:0]         RST_DELTA_PERCENT      = 7'd20;
  localparam logic signed [11:0] RST_HEATER_ON_TEMP     = 12'sd600;
  localparam logic signed [11:0] RST_HEATER_OFF_TEMP    = 12'sd700;
  localparam logic [31:0]        RST_INACTIVITY_TIMEOUT = 32'd60000;

  // Door handling timings, ms
  localparam logic [31:0] DOOR_BEEP_DELAY  = 32'd5000;
  localparam logic [31:0] DOOR_BEEP_PERIOD = 32'd10000;
  localparam logic [31:0] DOOR_ABORT_TIME  = 32'd300000;

  // Operation codes carried on tuser
  localparam logic OP_EVAL  = 1'b0;
  localparam logic OP_POWER = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HEATING = 3'd1,
    PH_DRYING  = 3'd2,
    PH_STABLE  = 3'd3,
    PH_COOLING = 3'd4
  } phase_t;

  // Input word, packed as on the stream (op on top, from tuser)
  typedef struct packed {
    logic              op;
    logic signed [11:0] delta_temp;
    logic signed [11:0] temp_in;
    logic              door_closed;
    logic [31:0]       now_ms;
    logic              power_request;
  } dcs_item_t;

  // Result word, lowest field last
  typedef struct packed {
    logic       event_door;
    logic       event_finish;
    logic       event_sleep;
    logic       event_start;
    logic       cooling;
    logic       powered;
    logic       running;
    logic [2:0] phase;
    logic       fan_on;
    logic       heater_on;
  } dcs_result_t;

  typedef struct packed {
    logic [31:0]       heat_phase_time;
    logic [31:0]       dry_phase_limit;
    logic [31:0]       stable_phase_time;
    logic [31:0]       cooling_time;
    logic [6:0]        delta_percent;
    logic signed [11:0] heater_on_temp;
    logic signed [11:0] heater_off_temp;
    logic [31:0]       inactivity_timeout;
  } dcs_cfg_t;

  typedef struct packed {
    logic        running_flag;
    logic        power_flag;
    logic        heater_flag;
    logic        heater_allow;
    logic        fan_flag;
    logic        fan_allow;
    logic        cooling_flag;
    phase_t      phase_reg;
    logic [31:0] start_stamp;
    logic [31:0] delta_stamp;
    logic [31:0] cooling_stamp;
    logic [31:0] on_stamp;
    logic [31:0] door_closed_stamp;
    logic [31:0] door_beep_stamp;
    logic [31:0] door_abort_stamp;
  } dcs_state_t;

  // Wrapping elapsed time
  function automatic logic [31:0] elapsed(input logic [31:0] now, input logic [31:0] stamp);
    elapsed = now - stamp;
  endfunction

endpackage

/* rtl/dryer_cycle_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// dryer_cycle_sequencer_unit
// Dryer phase sequencer: power commands and periodic control evaluations.
// ----------------------------------------------------------------------------
// Use:
//   s_* stream: one word per command. tuser = op (0 evaluate, 1 power).
//   m_* stream: one result word per input word, in order.
//   cfg_*: write-only register port, written while the stream is quiet.
// Path: a word accepted on s_* goes through the input register, then the
//   result register, to m_tdata.
// Throughput: one word per cycle while m_tready allows it. The state update
//   for a word is combinational between the input and result registers and
//   is registered with the result, so the next word sees it straight away.
// Reset (rst, synchronous): registers return to their default values, the
//   dryer state is cleared to idle and both stages are emptied.
// Stall: when m_tready is low the result stays on m_tdata; an empty input
//   stage takes one more word, then s_tready drops until the result goes.
// ----------------------------------------------------------------------------
module dryer_cycle_sequencer_unit
  import dcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // power_request[0], now_ms[32:1], door_closed[33], temp_in[45:34],
  // delta_temp[57:46], zero fill above
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // op[0]
  input  logic                  s_tuser,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // heater_on[0], fan_on[1], phase[4:2], running[5], powered[6], cooling[7],
  // event_start[8], event_sleep[9], event_finish[10], event_door[11]
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic        in_valid;
  dcs_item_t   in_item;
  logic        adv;
  dcs_state_t  st;
  dcs_state_t  st_next;
  dcs_cfg_t    cfg;
  dcs_result_t res;

  // Pipeline flow
  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      in_item <= {s_tuser, s_tdata[IN_USED_W-1:0]};
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heat_phase_time    <= RST_HEAT_PHASE_TIME;
      cfg.dry_phase_limit    <= RST_DRY_PHASE_LIMIT;
      cfg.stable_phase_time  <= RST_STABLE_PHASE_TIME;
      cfg.cooling_time       <= RST_COOLING_TIME;
      cfg.delta_percent      <= RST_DELTA_PERCENT;
      cfg.heater_on_temp     <= RST_HEATER_ON_TEMP;
      cfg.heater_off_temp    <= RST_HEATER_OFF_TEMP;
      cfg.inactivity_timeout <= RST_INACTIVITY_TIMEOUT;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_HEAT_PHASE_TIME:    cfg.heat_phase_time    <= cfg_data;
        REG_DRY_PHASE_LIMIT:    cfg.dry_phase_limit    <= cfg_data;
        REG_STABLE_PHASE_TIME:  cfg.stable_phase_time  <= cfg_data;
        REG_COOLING_TIME:       cfg.cooling_time       <= cfg_data;
        REG_DELTA_PERCENT:      cfg.delta_percent      <= cfg_data[6:0];
        REG_HEATER_ON_TEMP:     cfg.heater_on_temp     <= $signed(cfg_data[11:0]);
        REG_HEATER_OFF_TEMP:    cfg.heater_off_temp    <= $signed(cfg_data[11:0]);
        REG_INACTIVITY_TIMEOUT: cfg.inactivity_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-word update logic
  dcs_step u_step (
    .item    (in_item),
    .st      (st),
    .cfg     (cfg),
    .st_next (st_next),
    .res     (res)
  );

  // Dryer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (adv) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (adv) begin
      m_tdata <= {{(OUT_DATA_W-OUT_USED_W){1'b0}}, res};
    end
  end

  // Checks
  a_adv_fills_out: assert property (@(posedge clk) disable iff (rst)
    adv |=> m_tvalid)
    else $error("result register not loaded after advance");

  a_power_no_events: assert property (@(posedge clk) disable iff (rst)
    adv && in_item.op == OP_POWER |=> m_tdata[11:8] == 4'd0)
    else $error("event raised by a power command");

  a_stopped_is_idle: assert property (@(posedge clk) disable iff (rst)
    adv && in_item.op == OP_EVAL && in_item.door_closed && !st_next.running_flag
    |=> m_tdata[4:2] == PH_IDLE && !m_tdata[0] && !m_tdata[1])
    else $error("stopped dryer left a phase or an actuator active");

endmodule

/* rtl/dcs_step.sv */
// ----------------------------------------------------------------------------
// dcs_step
// Next-state and result logic for one word: power command or evaluation.
// ----------------------------------------------------------------------------
module dcs_step
  import dcs_pkg::*;
(
  input  dcs_item_t   item,
  input  dcs_state_t  st,
  input  dcs_cfg_t    cfg,
  output dcs_state_t  st_next,
  output dcs_result_t res
);

  logic signed [20:0] d100;
  logic signed [20:0] lim;
  logic               delta_lt;
  logic               delta_gt;

  // Delta test: delta*100 against temp*percent, both fit in 21 bits
  always_comb begin
    d100     = 21'(item.delta_temp) * 21'sd100;
    lim      = 21'(item.temp_in) * $signed({14'd0, cfg.delta_percent});
    delta_lt = d100 < lim;
    delta_gt = d100 > lim;
  end

  // Sequenced update of the state for one word
  always_comb begin
    dcs_state_t  nx;
    logic        ev_start;
    logic        ev_sleep;
    logic        ev_finish;
    logic        ev_door;
    logic [31:0] now;

    nx        = st;
    ev_start  = 1'b0;
    ev_sleep  = 1'b0;
    ev_finish = 1'b0;
    ev_door   = 1'b0;
    now       = item.now_ms;

    if (item.op == OP_POWER) begin
      nx.power_flag = item.power_request;
      if (item.power_request) begin
        nx.heater_allow      = 1'b1;
        nx.fan_allow         = 1'b1;
        nx.running_flag      = 1'b1;
        nx.start_stamp       = now;
        nx.delta_stamp       = now;
        nx.cooling_stamp     = now;
        nx.on_stamp          = now;
        nx.door_closed_stamp = now;
        nx.door_beep_stamp   = now;
        nx.door_abort_stamp  = now;
      end else begin
        nx.heater_allow = 1'b0;
        nx.fan_allow    = 1'b0;
        nx.running_flag = 1'b0;
      end
    end else if (item.door_closed) begin
      // start of a cycle, or a stop after power off
      if (nx.running_flag && nx.power_flag && nx.phase_reg == PH_IDLE) begin
        nx.heater_flag  = 1'b1;
        nx.heater_allow = 1'b1;
        nx.fan_flag     = 1'b1;
        nx.fan_allow    = 1'b1;
        nx.phase_reg    = PH_HEATING;
        nx.start_stamp  = now;
        ev_start        = 1'b1;
      end else if (nx.running_flag && !nx.power_flag) begin
        nx.running_flag = 1'b0;
        nx.heater_flag  = 1'b0;
        nx.fan_flag     = 1'b0;
        nx.phase_reg    = PH_IDLE;
        nx.on_stamp     = now;
        ev_sleep        = 1'b1;
      end
      // inactivity shutoff
      if (nx.power_flag && elapsed(now, nx.on_stamp) > cfg.inactivity_timeout) begin
        nx.running_flag = 1'b0;
        nx.power_flag   = 1'b0;
        nx.heater_flag  = 1'b0;
        nx.heater_allow = 1'b0;
        nx.fan_flag     = 1'b0;
        nx.phase_reg    = PH_IDLE;
        nx.on_stamp     = now;
        ev_finish       = 1'b1;
      end
      // heating done
      if (elapsed(now, nx.start_stamp) > cfg.heat_phase_time && nx.phase_reg == PH_HEATING) begin
        nx.phase_reg   = PH_DRYING;
        nx.delta_stamp = now;
      end
      // drying: watch the delta
      if (nx.phase_reg == PH_DRYING) begin
        if (delta_lt && nx.heater_flag) nx.phase_reg = PH_STABLE;
        nx.delta_stamp = now;
      end
      // drying time limit
      if (nx.phase_reg == PH_DRYING && elapsed(now, nx.start_stamp) > cfg.dry_phase_limit) begin
        nx.phase_reg     = PH_COOLING;
        nx.cooling_flag  = 1'b1;
        nx.heater_flag   = 1'b0;
        nx.cooling_stamp = now;
        ev_sleep         = 1'b1;
      end
      // stable falls back to drying when the delta rises
      if (nx.phase_reg == PH_STABLE && delta_gt && nx.heater_allow) begin
        nx.phase_reg   = PH_DRYING;
        nx.delta_stamp = now;
      end
      // stable held long enough
      if (elapsed(now, nx.delta_stamp) > cfg.stable_phase_time && nx.phase_reg == PH_STABLE) begin
        if (delta_lt) begin
          nx.phase_reg     = PH_COOLING;
          nx.cooling_flag  = 1'b1;
          nx.heater_allow  = 1'b0;
          nx.cooling_stamp = now;
          ev_sleep         = 1'b1;
        end else begin
          nx.phase_reg   = PH_DRYING;
          nx.delta_stamp = now;
        end
      end
      // cooling done
      if (elapsed(now, nx.cooling_stamp) > cfg.cooling_time && nx.phase_reg == PH_COOLING) begin
        nx.running_flag = 1'b0;
        nx.fan_flag     = 1'b0;
        nx.power_flag   = 1'b0;
        nx.phase_reg    = PH_IDLE;
        ev_finish       = 1'b1;
      end

      nx.door_closed_stamp = now;
      nx.door_beep_stamp   = now;
      nx.door_abort_stamp  = now;
      nx.on_stamp          = now;

      // actuators
      if (nx.running_flag) begin
        nx.heater_flag = nx.heater_allow ? (item.temp_in < cfg.heater_on_temp) : 1'b0;
        nx.fan_flag    = nx.fan_allow;
        if (item.temp_in >= cfg.heater_off_temp) nx.heater_flag = 1'b0;
      end else begin
        nx.heater_flag  = 1'b0;
        nx.heater_allow = 1'b0;
        nx.fan_flag     = 1'b0;
        nx.fan_allow    = 1'b0;
        nx.power_flag   = 1'b0;
        nx.cooling_flag = 1'b0;
        nx.phase_reg    = PH_IDLE;
      end
    end else begin
      // door open: pause timers and beep
      if (nx.running_flag) begin
        if (elapsed(now, nx.door_closed_stamp) > DOOR_BEEP_DELAY) begin
          if (elapsed(now, nx.door_beep_stamp) > DOOR_BEEP_PERIOD) begin
            ev_door            = 1'b1;
            nx.door_beep_stamp = now;
            nx.start_stamp     = now;
            nx.delta_stamp     = now;
            nx.cooling_stamp   = now;
          end
        end else begin
          nx.start_stamp   = now;
          nx.delta_stamp   = now;
          nx.cooling_stamp = now;
        end
        nx.fan_flag    = 1'b0;
        nx.heater_flag = 1'b0;
      end
      // abort after a long open door
      if (elapsed(now, nx.door_abort_stamp) > DOOR_ABORT_TIME && nx.phase_reg != PH_IDLE) begin
        nx.power_flag   = 1'b0;
        nx.running_flag = 1'b0;
        nx.heater_flag  = 1'b0;
        nx.heater_allow = 1'b0;
        nx.fan_flag     = 1'b0;
        nx.fan_allow    = 1'b0;
        nx.cooling_flag = 1'b0;
        nx.phase_reg    = PH_IDLE;
        ev_sleep        = 1'b1;
      end
    end

    st_next          = nx;
    res.heater_on    = nx.heater_flag;
    res.fan_on       = nx.fan_flag;
    res.phase        = nx.phase_reg;
    res.running      = nx.running_flag;
    res.powered      = nx.power_flag;
    res.cooling      = nx.cooling_flag;
    res.event_start  = ev_start;
    res.event_sleep  = ev_sleep;
    res.event_finish = ev_finish;
    res.event_door   = ev_door;
  end

endmodule
